@@ src/vapa_pkg.sv @@
// vapa_pkg: shared types, request codes and the note step table for the
// voice allocator and phase accumulator block
// no dependencies

package vapa_pkg;

    localparam int VOICE_COUNT_DEF   = 8;
    localparam int FRACTION_BITS_DEF = 11;

    localparam int NOTE_W   = 7;
    localparam int CHAN_W   = 4;
    localparam int CTL_W    = 7;
    localparam int REQ_W    = 3;
    localparam int LEN_W    = 16;
    localparam int STEP_W   = 16;
    localparam int POS_W    = 16;
    localparam int OWNER_W  = CHAN_W + 1;
    localparam int NOTE_CNT = 128;

    localparam logic [OWNER_W-1:0] NO_OWNER          = OWNER_W'(16);
    localparam logic [CTL_W-1:0]   SUSTAIN_THRESHOLD = CTL_W'(50);
    localparam logic [LEN_W-1:0]   LEN_RESET         = 16'hFFFF;

    localparam logic [63:0] STEP_NUM = 64'd1565599539;
    localparam logic [63:0] STEP_DEN = 64'd1000000000;

    typedef enum logic [REQ_W-1:0] {
        REQ_NOTE_ON  = 3'd0,
        REQ_NOTE_OFF = 3'd1,
        REQ_TICK     = 3'd2,
        REQ_ALL_OFF  = 3'd3,
        REQ_SUSTAIN  = 3'd4
    } req_t;

    typedef struct packed {
        logic fits;
        logic greater;
    } alu_flags_t;

    typedef logic [0:NOTE_CNT-1][15:0]     note_hz_t;
    typedef logic [0:NOTE_CNT-1][STEP_W-1:0] step_rom_t;

    localparam note_hz_t NOTE_HZ = '{
        16'd16, 16'd17, 16'd18, 16'd19, 16'd21, 16'd22, 16'd23, 16'd24,
        16'd26, 16'd28, 16'd29, 16'd31, 16'd33, 16'd35, 16'd37, 16'd39,
        16'd41, 16'd44, 16'd46, 16'd49, 16'd52, 16'd55, 16'd58, 16'd62,
        16'd65, 16'd69, 16'd73, 16'd78, 16'd82, 16'd87, 16'd92, 16'd98,
        16'd104, 16'd110, 16'd117, 16'd123, 16'd131, 16'd139, 16'd147, 16'd156,
        16'd165, 16'd175, 16'd185, 16'd196, 16'd208, 16'd220, 16'd233, 16'd247,
        16'd262, 16'd277, 16'd294, 16'd311, 16'd330, 16'd349, 16'd370, 16'd392,
        16'd415, 16'd440, 16'd466, 16'd494, 16'd523, 16'd554, 16'd587, 16'd622,
        16'd659, 16'd698, 16'd740, 16'd784, 16'd831, 16'd880, 16'd932, 16'd988,
        16'd1047, 16'd1109, 16'd1175, 16'd1245, 16'd1319, 16'd1397, 16'd1480,
        16'd1568, 16'd1661, 16'd1760, 16'd1865, 16'd1976, 16'd2093, 16'd2217,
        16'd2349, 16'd2489, 16'd2637, 16'd2794, 16'd2960, 16'd3136, 16'd3322,
        16'd3520, 16'd3729, 16'd3951, 16'd4186, 16'd4435, 16'd4699, 16'd4978,
        16'd5274, 16'd5588, 16'd5920, 16'd6272, 16'd6645, 16'd7040, 16'd7459,
        16'd7902, 16'd8372, 16'd8870, 16'd9397, 16'd9956, 16'd10548, 16'd11175,
        16'd11840, 16'd12544, 16'd13290, 16'd14080, 16'd14917, 16'd15804,
        16'd16744, 16'd17740, 16'd18795, 16'd19912, 16'd21096, 16'd22351,
        16'd23680, 16'd25088
    };

    // step = floor(hz * 1.565599539), evaluated at elaboration
    function automatic step_rom_t build_step_rom();
        step_rom_t   rom;
        logic [63:0] prod;
        for (int i = 0; i < NOTE_CNT; i++) begin
            prod   = 64'(NOTE_HZ[i]) * STEP_NUM;
            rom[i] = STEP_W'(prod / STEP_DEN);
        end
        return rom;
    endfunction

    localparam step_rom_t STEP_ROM = build_step_rom();

endpackage

@@ src/vapa_voice_alu.sv @@
// vapa_voice_alu: shared phase unit, one voice per use: phase plus step,
// end-of-sample compare and the largest-phase compare for voice stealing
// depends on vapa_pkg

module vapa_voice_alu #(
    parameter int FRACTION_BITS = vapa_pkg::FRACTION_BITS_DEF,
    parameter int PHASE_W       = vapa_pkg::LEN_W + FRACTION_BITS + 1
) (
    input  logic [PHASE_W-1:0]             phase,
    input  logic [vapa_pkg::STEP_W-1:0]    step,
    input  logic [PHASE_W-1:0]             best,
    input  logic [vapa_pkg::LEN_W-1:0]     sample_length,
    output logic [PHASE_W-1:0]             sum,
    output vapa_pkg::alu_flags_t           flags
);

    localparam int INT_W = PHASE_W - FRACTION_BITS;

    assign sum = phase + PHASE_W'(step);

    always_comb begin
        flags.fits    = sum[PHASE_W-1:FRACTION_BITS] < INT_W'(sample_length);
        flags.greater = phase > best;
    end

endmodule

@@ src/voice_allocator_phase_accumulator.sv @@
// voice_allocator_phase_accumulator: top level, voice state, sequencer
// and output register; depends on vapa_pkg and vapa_voice_alu
//
// Usage:
//   s_ channel: one request per beat, kind in s_tuser (note on, note off,
//   tick, all notes off, set sustain), note/channel/pedal value in s_tdata.
//   m_ channel: results. note on gives one beat with the chosen voice;
//   tick gives VOICE_COUNT beats, one per voice in index order, with the
//   sample position; m_tlast marks the final beat of a request.
//   cfg_ channel: sample length write, always ready; user must write while idle.
// Request handling (one shared phase unit, one voice per cycle unless stalled):
//   note on: a scan of every voice, then a commit of the chosen voice.
//   tick: one voice per cycle, every voice in index order, with a result each.
//   note off, all notes off: walk the voice table, no result.
//   set sustain: taken while idle, no result.
//   s_tready is high only between requests.
// Reset clears every voice and sustain and sets sample length to 65535.
// When m_tready is low with a beat waiting, a tick walk or note on commit
// holds on its voice and the finished beat waits in the output register.

module voice_allocator_phase_accumulator #(
    parameter int VOICE_COUNT   = vapa_pkg::VOICE_COUNT_DEF,
    parameter int FRACTION_BITS = vapa_pkg::FRACTION_BITS_DEF,
    parameter int VI_W          = $clog2(VOICE_COUNT),
    parameter int M_DATA_W      = ((VI_W + 1 + vapa_pkg::POS_W + 7) / 8) * 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [6:0] note_number, [10:7] midi_channel, [17:11] control_value
    input  logic [23:0]                    s_tdata,
    // [2:0] req_type
    input  logic [vapa_pkg::REQ_W-1:0]     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [VI_W-1:0] voice_index, [VI_W] voice_active, then sample_position
    output logic [M_DATA_W-1:0]            m_tdata,
    output logic                           m_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [vapa_pkg::LEN_W-1:0]     cfg_data
);

    localparam int PHASE_W = vapa_pkg::LEN_W + FRACTION_BITS + 1;
    localparam int POS_W   = vapa_pkg::POS_W;
    localparam int PAD_W   = M_DATA_W - VI_W - 1 - POS_W;
    localparam logic [VI_W-1:0] LAST_IDX = VI_W'(VOICE_COUNT - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_ON,
        ST_COMMIT,
        ST_NOTE_OFF,
        ST_TICK,
        ST_ALL_OFF
    } state_t;

    state_t                            state_reg;
    logic [VI_W-1:0]                   idx_reg;
    logic [vapa_pkg::NOTE_W-1:0]       note_reg;
    logic [vapa_pkg::CHAN_W-1:0]       chan_reg;
    logic                              sustain_reg;
    logic [vapa_pkg::LEN_W-1:0]        len_reg;

    logic [vapa_pkg::NOTE_W-1:0]       held_reg  [VOICE_COUNT];
    logic [vapa_pkg::OWNER_W-1:0]      owner_reg [VOICE_COUNT];
    logic [PHASE_W-1:0]                phase_reg [VOICE_COUNT];
    logic [vapa_pkg::STEP_W-1:0]       step_reg  [VOICE_COUNT];
    logic [VOICE_COUNT-1:0]            busy_reg;

    logic                              match_found_reg;
    logic [VI_W-1:0]                   match_idx_reg;
    logic                              free_found_reg;
    logic [VI_W-1:0]                   free_idx_reg;
    logic [PHASE_W-1:0]                best_reg;
    logic [VI_W-1:0]                   best_idx_reg;

    logic                              m_valid_reg;
    logic [VI_W-1:0]                   m_index_reg;
    logic                              m_active_reg;
    logic [POS_W-1:0]                  m_pos_reg;
    logic                              m_last_reg;

    logic [PHASE_W-1:0]                alu_sum;
    vapa_pkg::alu_flags_t              alu_flags;
    logic [VI_W-1:0]                   pick;
    logic                              out_free;
    logic                              m_load;
    logic                              idx_last;
    logic [PHASE_W-1:0]                park_phase;
    logic [PHASE_W-1:0]                tick_phase;
    vapa_pkg::req_t                    s_req;
    logic [vapa_pkg::NOTE_W-1:0]       s_note;
    logic [vapa_pkg::CHAN_W-1:0]       s_chan;
    logic [vapa_pkg::CTL_W-1:0]        s_ctl;

    vapa_voice_alu #(
        .FRACTION_BITS (FRACTION_BITS),
        .PHASE_W       (PHASE_W)
    ) u_alu (
        .phase         (phase_reg[idx_reg]),
        .step          (step_reg[idx_reg]),
        .best          (best_reg),
        .sample_length (len_reg),
        .sum           (alu_sum),
        .flags         (alu_flags)
    );

    assign s_req  = vapa_pkg::req_t'(s_tuser);
    assign s_note = s_tdata[6:0];
    assign s_chan = s_tdata[10:7];
    assign s_ctl  = s_tdata[17:11];

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tlast   = m_last_reg;
    assign m_tdata   = {PAD_W'(0), m_pos_reg, m_active_reg, m_index_reg};

    assign out_free   = !m_valid_reg || m_tready;
    assign m_load     = out_free && (state_reg == ST_COMMIT || state_reg == ST_TICK);
    assign idx_last   = (idx_reg == LAST_IDX);
    assign park_phase = PHASE_W'(len_reg) << FRACTION_BITS;
    assign tick_phase = alu_flags.fits ? alu_sum : phase_reg[idx_reg];

    always_comb begin
        if (match_found_reg) begin
            pick = match_idx_reg;
        end else if (free_found_reg) begin
            pick = free_idx_reg;
        end else begin
            pick = best_idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            idx_reg         <= '0;
            sustain_reg     <= 1'b0;
            len_reg         <= vapa_pkg::LEN_RESET;
            busy_reg        <= '0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            m_valid_reg     <= 1'b0;
            m_last_reg      <= 1'b0;
            for (int v = 0; v < VOICE_COUNT; v++) begin
                held_reg[v]  <= '0;
                owner_reg[v] <= vapa_pkg::NO_OWNER;
                phase_reg[v] <= '0;
                step_reg[v]  <= '0;
            end
        end else begin
            if (cfg_valid) begin
                len_reg <= cfg_data;
            end
            if (m_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        note_reg        <= s_note;
                        chan_reg        <= s_chan;
                        idx_reg         <= '0;
                        match_found_reg <= 1'b0;
                        free_found_reg  <= 1'b0;
                        best_reg        <= '0;
                        best_idx_reg    <= '0;
                        case (s_req)
                            vapa_pkg::REQ_NOTE_ON: begin
                                state_reg <= ST_SCAN_ON;
                            end
                            vapa_pkg::REQ_NOTE_OFF: begin
                                if (!sustain_reg) begin
                                    state_reg <= ST_NOTE_OFF;
                                end
                            end
                            vapa_pkg::REQ_TICK: begin
                                state_reg <= ST_TICK;
                            end
                            vapa_pkg::REQ_ALL_OFF: begin
                                state_reg <= ST_ALL_OFF;
                            end
                            vapa_pkg::REQ_SUSTAIN: begin
                                sustain_reg <= (s_ctl > vapa_pkg::SUSTAIN_THRESHOLD);
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_SCAN_ON: begin
                    if (!match_found_reg && held_reg[idx_reg] == note_reg) begin
                        match_found_reg <= 1'b1;
                        match_idx_reg   <= idx_reg;
                    end
                    if (!free_found_reg) begin
                        if (!busy_reg[idx_reg]) begin
                            free_found_reg <= 1'b1;
                            free_idx_reg   <= idx_reg;
                        end else if (alu_flags.greater) begin
                            best_reg     <= phase_reg[idx_reg];
                            best_idx_reg <= idx_reg;
                        end
                    end
                    if (idx_last) begin
                        idx_reg   <= '0;
                        state_reg <= ST_COMMIT;
                    end else begin
                        idx_reg <= idx_reg + VI_W'(1);
                    end
                end
                ST_COMMIT: begin
                    if (out_free) begin
                        owner_reg[pick] <= {1'b0, chan_reg};
                        phase_reg[pick] <= '0;
                        step_reg[pick]  <= vapa_pkg::STEP_ROM[note_reg];
                        busy_reg[pick]  <= 1'b1;
                        if (!match_found_reg) begin
                            held_reg[pick] <= note_reg;
                        end
                        m_index_reg  <= pick;
                        m_active_reg <= 1'b0;
                        m_pos_reg    <= '0;
                        m_last_reg   <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                ST_NOTE_OFF: begin
                    if (held_reg[idx_reg] == note_reg) begin
                        phase_reg[idx_reg] <= park_phase;
                        busy_reg[idx_reg]  <= 1'b0;
                        idx_reg            <= '0;
                        state_reg          <= ST_IDLE;
                    end else if (idx_last) begin
                        idx_reg   <= '0;
                        state_reg <= ST_IDLE;
                    end else begin
                        idx_reg <= idx_reg + VI_W'(1);
                    end
                end
                ST_TICK: begin
                    if (out_free) begin
                        phase_reg[idx_reg] <= tick_phase;
                        if (!alu_flags.fits) begin
                            busy_reg[idx_reg] <= 1'b0;
                        end
                        m_index_reg  <= idx_reg;
                        m_active_reg <= alu_flags.fits;
                        m_pos_reg    <= tick_phase[FRACTION_BITS +: POS_W];
                        m_last_reg   <= idx_last;
                        if (idx_last) begin
                            idx_reg   <= '0;
                            state_reg <= ST_IDLE;
                        end else begin
                            idx_reg <= idx_reg + VI_W'(1);
                        end
                    end
                end
                ST_ALL_OFF: begin
                    if (owner_reg[idx_reg] == {1'b0, chan_reg}) begin
                        owner_reg[idx_reg] <= vapa_pkg::NO_OWNER;
                        phase_reg[idx_reg] <= park_phase;
                        busy_reg[idx_reg]  <= 1'b0;
                    end
                    if (idx_last) begin
                        idx_reg   <= '0;
                        state_reg <= ST_IDLE;
                    end else begin
                        idx_reg <= idx_reg + VI_W'(1);
                    end
                end
                default: begin
                    idx_reg   <= '0;
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // walk counter rewinds before every request
    a_idle_idx_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (idx_reg == '0))
        else $error("voice counter not rewound at idle");

    // walk never leaves the voice range
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= LAST_IDX)
        else $error("voice counter out of range");

    // reported voice exists
    a_out_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[VI_W-1:0] <= LAST_IDX))
        else $error("result names a missing voice");

    // a tick beat starts the voice walk
    a_tick_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == vapa_pkg::REQ_TICK) |=> !s_tready)
        else $error("tick did not start the voice walk");

    // note on result carries no position
    a_note_on_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COMMIT && out_free) |=> (m_pos_reg == '0 && m_tlast))
        else $error("note on result malformed");
`endif

endmodule

@@ tb/vapa_result_checker.sv @@
// vapa_result_checker: watches the request, result and sample length channels,
// keeps its own voice table and compares every result beat in order
// depends on vapa_pkg for the request codes, voice count and fraction width

module vapa_result_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output int          mismatch_count,
    output int          results_pending
);

    localparam int VOICES = vapa_pkg::VOICE_COUNT_DEF;
    localparam int FRAC   = vapa_pkg::FRACTION_BITS_DEF;
    localparam int REPORT_LIMIT = 10;

    localparam logic [4:0]  UNOWNED        = 5'd16;
    localparam logic [6:0]  PEDAL_ON_ABOVE = 7'd50;
    localparam logic [63:0] STEP_MUL       = 64'd1565599539;
    localparam logic [63:0] STEP_DIV       = 64'd1000000000;

    // rounded equal-tempered pitch per note, in Hz
    localparam logic [0:127][15:0] PITCH_HZ = {
        16'd16, 16'd17, 16'd18, 16'd19, 16'd21, 16'd22, 16'd23, 16'd24,
        16'd26, 16'd28, 16'd29, 16'd31, 16'd33, 16'd35, 16'd37, 16'd39,
        16'd41, 16'd44, 16'd46, 16'd49, 16'd52, 16'd55, 16'd58, 16'd62,
        16'd65, 16'd69, 16'd73, 16'd78, 16'd82, 16'd87, 16'd92, 16'd98,
        16'd104, 16'd110, 16'd117, 16'd123, 16'd131, 16'd139, 16'd147, 16'd156,
        16'd165, 16'd175, 16'd185, 16'd196, 16'd208, 16'd220, 16'd233, 16'd247,
        16'd262, 16'd277, 16'd294, 16'd311, 16'd330, 16'd349, 16'd370, 16'd392,
        16'd415, 16'd440, 16'd466, 16'd494, 16'd523, 16'd554, 16'd587, 16'd622,
        16'd659, 16'd698, 16'd740, 16'd784, 16'd831, 16'd880, 16'd932, 16'd988,
        16'd1047, 16'd1109, 16'd1175, 16'd1245, 16'd1319, 16'd1397, 16'd1480,
        16'd1568, 16'd1661, 16'd1760, 16'd1865, 16'd1976, 16'd2093, 16'd2217,
        16'd2349, 16'd2489, 16'd2637, 16'd2794, 16'd2960, 16'd3136, 16'd3322,
        16'd3520, 16'd3729, 16'd3951, 16'd4186, 16'd4435, 16'd4699, 16'd4978,
        16'd5274, 16'd5588, 16'd5920, 16'd6272, 16'd6645, 16'd7040, 16'd7459,
        16'd7902, 16'd8372, 16'd8870, 16'd9397, 16'd9956, 16'd10548, 16'd11175,
        16'd11840, 16'd12544, 16'd13290, 16'd14080, 16'd14917, 16'd15804,
        16'd16744, 16'd17740, 16'd18795, 16'd19912, 16'd21096, 16'd22351,
        16'd23680, 16'd25088
    };

    typedef struct packed {
        logic [2:0]  voice;
        logic        active;
        logic [15:0] position;
        logic        last;
    } voice_beat_t;

    logic [6:0]  held_note  [VOICES];
    logic [4:0]  owner      [VOICES];
    logic        busy       [VOICES];
    logic [27:0] phase      [VOICES];
    logic [15:0] step       [VOICES];
    logic        sustain;
    logic [15:0] sample_len;

    voice_beat_t expected_beats[$];
    int          fail_total = 0;

    function automatic logic [15:0] pitch_step(input logic [6:0] note);
        logic [63:0] prod;
        prod = 64'(PITCH_HZ[note]) * STEP_MUL;
        return 16'(prod / STEP_DIV);
    endfunction

    function automatic voice_beat_t make_beat(input int voice, input logic active,
                                              input logic [27:0] ph, input logic last);
        return {3'(voice), active, 16'(ph >> FRAC), last};
    endfunction

    task automatic apply_request(input logic [2:0] kind, input logic [6:0] note,
                                 input logic [3:0] chan, input logic [6:0] ctl);
        int          pick;
        logic [27:0] best;
        logic [27:0] next_phase;
        logic        hit;
        logic        free_found;
        logic        act;
        pick       = 0;
        best       = '0;
        hit        = 1'b0;
        free_found = 1'b0;
        case (kind)
            vapa_pkg::REQ_NOTE_ON: begin
                for (int v = 0; v < VOICES; v++) begin
                    if (!hit && held_note[v] == note) begin
                        hit  = 1'b1;
                        pick = v;
                    end
                end
                if (!hit) begin
                    for (int v = 0; v < VOICES; v++) begin
                        if (!free_found) begin
                            if (!busy[v]) begin
                                pick       = v;
                                free_found = 1'b1;
                            end else if (phase[v] > best) begin
                                best = phase[v];
                                pick = v;
                            end
                        end
                    end
                    held_note[pick] = note;
                end
                owner[pick] = {1'b0, chan};
                phase[pick] = '0;
                step[pick]  = pitch_step(note);
                busy[pick]  = 1'b1;
                expected_beats.push_back(make_beat(pick, 1'b0, '0, 1'b1));
            end
            vapa_pkg::REQ_NOTE_OFF: begin
                if (!sustain) begin
                    for (int v = 0; v < VOICES; v++) begin
                        if (!hit && held_note[v] == note) begin
                            hit      = 1'b1;
                            phase[v] = 28'(sample_len) << FRAC;
                            busy[v]  = 1'b0;
                        end
                    end
                end
            end
            vapa_pkg::REQ_TICK: begin
                for (int v = 0; v < VOICES; v++) begin
                    next_phase = phase[v] + 28'(step[v]);
                    act = (next_phase >> FRAC) < 28'(sample_len);
                    if (act)
                        phase[v] = next_phase;
                    else
                        busy[v] = 1'b0;
                    expected_beats.push_back(make_beat(v, act, phase[v], v == VOICES - 1));
                end
            end
            vapa_pkg::REQ_ALL_OFF: begin
                for (int v = 0; v < VOICES; v++) begin
                    if (owner[v] == {1'b0, chan}) begin
                        owner[v] = UNOWNED;
                        phase[v] = 28'(sample_len) << FRAC;
                        busy[v]  = 1'b0;
                    end
                end
            end
            vapa_pkg::REQ_SUSTAIN: begin
                sustain = ctl > PEDAL_ON_ABOVE;
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge aclk) begin
        voice_beat_t got;
        voice_beat_t want;
        if (!aresetn) begin
            for (int v = 0; v < VOICES; v++) begin
                held_note[v] = '0;
                owner[v]     = UNOWNED;
                busy[v]      = 1'b0;
                phase[v]     = '0;
                step[v]      = '0;
            end
            sustain    = 1'b0;
            sample_len = 16'hFFFF;
            expected_beats.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                sample_len = cfg_data;
            if (m_tvalid && m_tready) begin
                got = {m_tdata[2:0], m_tdata[3], m_tdata[19:4], m_tlast};
                if (expected_beats.size() == 0) begin
                    fail_total++;
                    if (fail_total <= REPORT_LIMIT)
                        $display("unexpected result beat: voice %0d active %0d position %0d last %0d",
                                 got.voice, got.active, got.position, got.last);
                end else begin
                    want = expected_beats.pop_front();
                    if (got.voice !== want.voice || got.active !== want.active ||
                        got.position !== want.position || got.last !== want.last) begin
                        fail_total++;
                        if (fail_total <= REPORT_LIMIT)
                            $display({"result mismatch: expected voice %0d active %0d position %0d",
                                      " last %0d, got voice %0d active %0d position %0d last %0d"},
                                     want.voice, want.active, want.position, want.last,
                                     got.voice, got.active, got.position, got.last);
                    end
                end
            end
            if (s_tvalid && s_tready)
                apply_request(s_tuser, s_tdata[6:0], s_tdata[10:7], s_tdata[17:11]);
        end
        mismatch_count  <= fail_total;
        results_pending <= expected_beats.size();
    end

endmodule

@@ tb/testbench.sv @@
// testbench: drives every request kind and sample length writes
// into voice_allocator_phase_accumulator; depends on vapa_pkg and vapa_result_checker

module testbench;

    localparam int REQ_FIRST_UNUSED = 5;
    localparam int PHASES           = 8;
    localparam int ITEMS_PER_PHASE  = 50;
    localparam int SETTLE_CYCLES    = 24;
    localparam int STALL_LIMIT      = 2000;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic [2:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b1;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data  = '0;

    int mismatch_count;
    int results_pending;
    int idle_pct   = 0;
    bit quiet_tail = 1'b0;
    int stall_left = 0;
    int quiet_cycles = 0;

    voice_allocator_phase_accumulator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    vapa_result_checker result_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result side back-pressure in bursts
    always @(posedge aclk) begin
        if (!aresetn || quiet_tail || idle_pct == 0) begin
            m_tready   <= 1'b1;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if ($urandom_range(99) < idle_pct) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(6, 0);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("voice_allocator_phase_accumulator test failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        return ($urandom_range(99) < idle_pct) ? int'($urandom_range(7, 1)) : 0;
    endfunction

    task automatic send_request(input logic [2:0] kind, input logic [6:0] note,
                                input logic [3:0] chan, input logic [6:0] ctl);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {6'b0, ctl, chan, note};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (results_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_sample_length(input logic [15:0] len);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_request(output logic [2:0] kind, output logic [6:0] note,
                                  output logic [3:0] chan, output logic [6:0] ctl);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 34)
            kind = vapa_pkg::REQ_NOTE_ON;
        else if (roll < 50)
            kind = vapa_pkg::REQ_NOTE_OFF;
        else if (roll < 80)
            kind = vapa_pkg::REQ_TICK;
        else if (roll < 86)
            kind = vapa_pkg::REQ_ALL_OFF;
        else if (roll < 94)
            kind = vapa_pkg::REQ_SUSTAIN;
        else
            kind = 3'($urandom_range(7, REQ_FIRST_UNUSED));
        // a narrow note pool forces retriggers, steals and note offs that hit
        note = ($urandom_range(9) < 7) ? 7'($urandom_range(59, 48)) : 7'($urandom);
        chan = ($urandom_range(9) < 7) ? 4'($urandom_range(3)) : 4'($urandom);
        ctl  = 7'($urandom);
    endtask

    initial begin
        logic [2:0]  kind;
        logic [6:0]  note;
        logic [3:0]  chan;
        logic [6:0]  ctl;
        logic [15:0] len;
        int          sent;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        idle_pct = 25;

        // note 0 matches every voice after reset, then fill all voices
        send_request(vapa_pkg::REQ_NOTE_ON, 7'd0, 4'd0, 7'($urandom));
        send_request(vapa_pkg::REQ_NOTE_ON, 7'd127, 4'd15, 7'($urandom));
        for (int n = 60; n < 66; n++)
            send_request(vapa_pkg::REQ_NOTE_ON, 7'(n), 4'd3, 7'($urandom));
        // steal with every phase still zero
        send_request(vapa_pkg::REQ_NOTE_ON, 7'd100, 4'd9, 7'($urandom));
        send_request(vapa_pkg::REQ_TICK, 7'($urandom), 4'($urandom), 7'($urandom));
        send_request(vapa_pkg::REQ_TICK, 7'($urandom), 4'($urandom), 7'($urandom));
        send_request(vapa_pkg::REQ_NOTE_ON, 7'd20, 4'd9, 7'($urandom));
        send_request(vapa_pkg::REQ_SUSTAIN, 7'($urandom), 4'($urandom), 7'd51);
        send_request(vapa_pkg::REQ_NOTE_OFF, 7'd61, 4'($urandom), 7'($urandom));
        send_request(vapa_pkg::REQ_SUSTAIN, 7'($urandom), 4'($urandom), 7'd50);
        send_request(vapa_pkg::REQ_NOTE_OFF, 7'd61, 4'($urandom), 7'($urandom));
        send_request(vapa_pkg::REQ_ALL_OFF, 7'($urandom), 4'd3, 7'($urandom));
        send_request(vapa_pkg::REQ_ALL_OFF, 7'($urandom), 4'd15, 7'($urandom));
        for (int k = REQ_FIRST_UNUSED; k < 8; k++)
            send_request(3'(k), 7'($urandom), 4'($urandom), 7'($urandom));
        send_request(vapa_pkg::REQ_SUSTAIN, 7'($urandom), 4'($urandom), 7'd127);
        send_request(vapa_pkg::REQ_SUSTAIN, 7'($urandom), 4'($urandom), 7'd0);
        send_request(vapa_pkg::REQ_NOTE_OFF, 7'd42, 4'($urandom), 7'($urandom));
        send_request(vapa_pkg::REQ_TICK, 7'($urandom), 4'($urandom), 7'($urandom));

        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            case (p)
                0:       len = 16'd40;
                1:       len = 16'd1;
                2:       len = 16'd0;
                3:       len = 16'hFFFF;
                4:       len = 16'd300;
                5:       len = 16'($urandom_range(200, 2));
                6:       len = 16'd8;
                default: len = 16'($urandom_range(65535, 1));
            endcase
            write_sample_length(len);
            quiet_tail = (p == PHASES - 1);
            idle_pct   = quiet_tail ? 0 : ((p % 3 == 2) ? 0 : 15 + 25 * (p % 3));
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                random_request(kind, note, chan, ctl);
                send_request(kind, note, chan, ctl);
                if (kind <= vapa_pkg::REQ_SUSTAIN)
                    sent++;
            end
        end
        drain_results();

        if (mismatch_count == 0 && results_pending == 0)
            $display("voice_allocator_phase_accumulator test passed");
        else
            $display("voice_allocator_phase_accumulator test failed");
        $finish;
    end

endmodule

@@ voice_allocator_phase_accumulator.f @@
src/vapa_pkg.sv
src/vapa_voice_alu.sv
src/voice_allocator_phase_accumulator.sv
tb/vapa_result_checker.sv
tb/testbench.sv
